FILE: rtl/core/lsps_pkg.sv
// shared constants, register codes and types of the line sensor pid steering block
package lsps_pkg;

  localparam int READING_BITS = 10;
  localparam int SENSOR_COUNT = 5;
  localparam int OFFSET_BITS  = 11;
  localparam int OFFSETS_W    = SENSOR_COUNT * OFFSET_BITS;
  localparam int THRESH_W     = 12;
  localparam int DATA_W       = 16;
  localparam int ERR_W        = 11;
  localparam int COUNT_W      = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = OFFSETS_W;
  localparam int ERR_DIVISOR  = 100;

  localparam int LEVEL_W = ((READING_BITS > OFFSET_BITS - 1) ? READING_BITS : OFFSET_BITS - 1) + 2;
  localparam int SUM_W   = LEVEL_W + 4;
  localparam int DIFF_W  = ((SUM_W > DATA_W) ? SUM_W : DATA_W) + 1;

  // reciprocal multiply for the divide by the error divisor
  localparam int DIV_SHIFT = DIFF_W + $clog2(ERR_DIVISOR);
  localparam int DIV_MUL_W = DIFF_W + 1;
  localparam int QUOT_W    = DIFF_W - $clog2(ERR_DIVISOR) + 1;
  localparam int DIV_PROD_W = DIFF_W + DIV_MUL_W;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL =
    DIV_MUL_W'(((64'd1 << DIV_SHIFT) + 64'(ERR_DIVISOR) - 64'd1) / 64'(ERR_DIVISOR));

  localparam int ERR_LIM     = 2 ** (ERR_W - 1);
  localparam int DRIVE_SUM_W = 2 * DATA_W + 2;

  localparam logic signed [ERR_W-1:0]  ERR_MIN  = {1'b1, {(ERR_W - 1){1'b0}}};
  localparam logic signed [ERR_W-1:0]  ERR_MAX  = {1'b0, {(ERR_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W - 1){1'b1}}};

  localparam logic signed [2:0] SENSOR_WEIGHT [SENSOR_COUNT] =
    '{3'sd3, 3'sd2, 3'sd1, -3'sd2, -3'sd3};

  localparam logic signed [THRESH_W-1:0] THRESH_RESET = 12'sd512;
  localparam logic signed [DATA_W-1:0]   GAIN_P_RESET = 16'sd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSETS   = 3'd0,
    CFG_THRESH    = 3'd1,
    CFG_MODE      = 3'd2,
    CFG_SET_POINT = 3'd3,
    CFG_GAIN_P    = 3'd4,
    CFG_GAIN_D    = 3'd5,
    CFG_GAIN_I    = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    MODE_DARK  = 1'b0,
    MODE_LIGHT = 1'b1
  } line_mode_e;

  typedef struct packed {
    logic [OFFSETS_W-1:0]        offsets;
    logic signed [THRESH_W-1:0]  threshold;
    line_mode_e                  mode;
    logic signed [DATA_W-1:0]    set_point;
    logic signed [DATA_W-1:0]    gain_p;
    logic signed [DATA_W-1:0]    gain_d;
    logic signed [DATA_W-1:0]    gain_i;
  } cfg_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0]  diff;
    logic [SENSOR_COUNT-1:0]   mask;
    logic [COUNT_W-1:0]        count;
  } front_t;

  typedef struct packed {
    logic              neg;
    logic [QUOT_W-1:0] mag;
  } quot_t;

endpackage

FILE: rtl/core/lsps_front.sv
// sensor front end: offset correction, line classification and weighted error sum
module lsps_front (
  input  lsps_pkg::cfg_t                     cfg_i,
  input  logic [lsps_pkg::READING_BITS-1:0]  raw_i [lsps_pkg::SENSOR_COUNT],
  output lsps_pkg::front_t                   front_o
);
  import lsps_pkg::*;

  logic signed [OFFSET_BITS-1:0] offset [SENSOR_COUNT];
  logic signed [LEVEL_W-1:0]     level [SENSOR_COUNT];
  logic signed [LEVEL_W-1:0]     thresh;
  logic [SENSOR_COUNT-1:0]       on;
  logic [COUNT_W-1:0]            count;
  logic signed [SUM_W-1:0]       sum;

  always_comb begin
    thresh = LEVEL_W'($signed(cfg_i.threshold));
    sum    = '0;
    count  = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      offset[i] = cfg_i.offsets[OFFSET_BITS*i +: OFFSET_BITS];
      level[i]  = $signed({{(LEVEL_W - READING_BITS){1'b0}}, raw_i[i]}) + LEVEL_W'(offset[i]);
      if (cfg_i.mode == MODE_DARK) begin
        on[i] = level[i] < thresh;
      end else begin
        on[i] = level[i] > thresh;
      end
      count = count + COUNT_W'(on[i]);
      sum   = sum + SUM_W'(level[i]) * SUM_W'(SENSOR_WEIGHT[i]);
    end
    front_o.mask  = on;
    front_o.count = count;
    front_o.diff  = DIFF_W'($signed(cfg_i.set_point)) - DIFF_W'(sum);
  end

endmodule

FILE: rtl/core/lsps_div100.sv
// divide by the error divisor through a reciprocal multiply, truncating toward zero
module lsps_div100 (
  input  logic signed [lsps_pkg::DIFF_W-1:0] diff_i,
  output lsps_pkg::quot_t                    quot_o
);
  import lsps_pkg::*;

  logic [DIFF_W-1:0]     mag;
  logic [DIV_PROD_W-1:0] prod;

  always_comb begin
    mag  = diff_i[DIFF_W-1] ? DIFF_W'(-diff_i) : DIFF_W'(diff_i);
    prod = DIV_PROD_W'(mag) * DIV_PROD_W'(DIV_MUL);
    quot_o.neg = diff_i[DIFF_W-1];
    quot_o.mag = prod[DIV_SHIFT +: QUOT_W];
  end

endmodule

FILE: rtl/core/line_sensor_pid_steering.sv
// top level of the line sensor pid steering block: config registers, pipeline and pid state
//
// channel  direction  handshake               payload
// in       input      in_valid_i/in_ready_o   sensor0..4_raw_i, restart_i
// out      output     out_valid_o/out_ready_i drive_o, on_line_mask_o, on_line_count_o,
//                                             error_value_o
// cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// one word per cycle sustained through a six register pipeline while out_ready_i stays high;
// the divide multiply owns one stage and the three gain multiplies share another
// a full stage holds while the next stage is full and holding, so words keep entering until all stages fill
// rst_ni clears the valid bits, the pid state and the config registers to their reset values
module line_sensor_pid_steering (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lsps_pkg::READING_BITS-1:0]   sensor0_raw_i,
  input  logic [lsps_pkg::READING_BITS-1:0]   sensor1_raw_i,
  input  logic [lsps_pkg::READING_BITS-1:0]   sensor2_raw_i,
  input  logic [lsps_pkg::READING_BITS-1:0]   sensor3_raw_i,
  input  logic [lsps_pkg::READING_BITS-1:0]   sensor4_raw_i,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lsps_pkg::DATA_W-1:0]  drive_o,
  output logic [lsps_pkg::SENSOR_COUNT-1:0]   on_line_mask_o,
  output logic [lsps_pkg::COUNT_W-1:0]        on_line_count_o,
  output logic signed [lsps_pkg::ERR_W-1:0]   error_value_o,
  input  logic                                cfg_we_i,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import lsps_pkg::*;

  localparam int PROD_P_W = DATA_W + ERR_W;
  localparam int PROD_D_W = DATA_W + ERR_W + 1;
  localparam int PROD_I_W = 2 * DATA_W;

  function automatic logic signed [DATA_W-1:0] sat_data(
    input logic signed [DRIVE_SUM_W-1:0] v
  );
    logic signed [DATA_W-1:0] r;
    if (v > DRIVE_SUM_W'(DATA_MAX)) begin
      r = DATA_MAX;
    end else if (v < DRIVE_SUM_W'(DATA_MIN)) begin
      r = DATA_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  cfg_t cfg_q;

  // pipeline control
  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q, e_valid_q, out_valid_q;
  logic load_a, load_b, load_c, load_d, load_e, load_out;

  // stage payloads
  logic [READING_BITS-1:0]      a_raw_q [SENSOR_COUNT];
  logic                         a_restart_q;
  front_t                       b_front_d, b_front_q;
  logic                         b_restart_q;
  quot_t                        c_quot_d, c_quot_q;
  logic [SENSOR_COUNT-1:0]      c_mask_q;
  logic [COUNT_W-1:0]           c_count_q;
  logic                         c_restart_q;
  logic signed [ERR_W-1:0]      d_err_d, d_err_q;
  logic signed [ERR_W:0]        d_derr_d, d_derr_q;
  logic signed [DATA_W-1:0]     d_integ_d, d_integ_q;
  logic [SENSOR_COUNT-1:0]      d_mask_q;
  logic [COUNT_W-1:0]           d_count_q;
  logic signed [PROD_P_W-1:0]   e_prod_p_d, e_prod_p_q;
  logic signed [PROD_D_W-1:0]   e_prod_d_d, e_prod_d_q;
  logic signed [PROD_I_W-1:0]   e_prod_i_d, e_prod_i_q;
  logic signed [ERR_W-1:0]      e_err_q;
  logic [SENSOR_COUNT-1:0]      e_mask_q;
  logic [COUNT_W-1:0]           e_count_q;
  logic signed [DATA_W-1:0]     drive_d, drive_q;
  logic [SENSOR_COUNT-1:0]      mask_q;
  logic [COUNT_W-1:0]           count_q;
  logic signed [ERR_W-1:0]      err_q;

  // pid state
  logic signed [ERR_W-1:0]      prev_err_d, prev_err_q;
  logic signed [DATA_W-1:0]     integ_d, integ_q;

  logic signed [ERR_W-1:0]      prev_eff;
  logic signed [QUOT_W:0]       mag_ext;
  logic signed [DRIVE_SUM_W-1:0] drive_sum;

  assign load_out   = !out_valid_q || out_ready_i;
  assign load_e     = !e_valid_q || load_out;
  assign load_d     = !d_valid_q || load_e;
  assign load_c     = !c_valid_q || load_d;
  assign load_b     = !b_valid_q || load_c;
  assign load_a     = !a_valid_q || load_b;
  assign in_ready_o = load_a;

  lsps_front u_front (
    .cfg_i   (cfg_q),
    .raw_i   (a_raw_q),
    .front_o (b_front_d)
  );

  lsps_div100 u_div (
    .diff_i (b_front_q.diff),
    .quot_o (c_quot_d)
  );

  // clamp the quotient, pick up the pid state and advance it
  always_comb begin
    mag_ext = $signed({1'b0, c_quot_q.mag});
    if (c_quot_q.neg) begin
      d_err_d = (c_quot_q.mag > QUOT_W'(ERR_LIM)) ? ERR_MIN : ERR_W'(-mag_ext);
    end else begin
      d_err_d = (c_quot_q.mag > QUOT_W'(ERR_LIM - 1)) ? ERR_MAX : ERR_W'(mag_ext);
    end
    prev_eff   = c_restart_q ? '0 : prev_err_q;
    d_integ_d  = c_restart_q ? '0 : integ_q;
    d_derr_d   = (ERR_W + 1)'(prev_eff) - (ERR_W + 1)'(d_err_d);
    prev_err_d = d_err_d;
    integ_d    = sat_data(DRIVE_SUM_W'(d_integ_d) + DRIVE_SUM_W'(d_err_d));
  end

  always_comb begin
    e_prod_p_d = PROD_P_W'(cfg_q.gain_p) * PROD_P_W'(d_err_q);
    e_prod_d_d = PROD_D_W'(cfg_q.gain_d) * PROD_D_W'(d_derr_q);
    e_prod_i_d = PROD_I_W'(cfg_q.gain_i) * PROD_I_W'(d_integ_q);
  end

  always_comb begin
    drive_sum = DRIVE_SUM_W'(e_prod_p_q) + DRIVE_SUM_W'(e_prod_d_q) + DRIVE_SUM_W'(e_prod_i_q);
    drive_d   = sat_data(drive_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offsets   <= '0;
      cfg_q.threshold <= THRESH_RESET;
      cfg_q.mode      <= MODE_DARK;
      cfg_q.set_point <= '0;
      cfg_q.gain_p    <= GAIN_P_RESET;
      cfg_q.gain_d    <= '0;
      cfg_q.gain_i    <= '0;
      a_valid_q       <= 1'b0;
      b_valid_q       <= 1'b0;
      c_valid_q       <= 1'b0;
      d_valid_q       <= 1'b0;
      e_valid_q       <= 1'b0;
      out_valid_q     <= 1'b0;
      prev_err_q      <= '0;
      integ_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_OFFSETS:   cfg_q.offsets   <= cfg_data_i[OFFSETS_W-1:0];
          CFG_THRESH:    cfg_q.threshold <= cfg_data_i[THRESH_W-1:0];
          CFG_MODE:      cfg_q.mode      <= line_mode_e'(cfg_data_i[0]);
          CFG_SET_POINT: cfg_q.set_point <= cfg_data_i[DATA_W-1:0];
          CFG_GAIN_P:    cfg_q.gain_p    <= cfg_data_i[DATA_W-1:0];
          CFG_GAIN_D:    cfg_q.gain_d    <= cfg_data_i[DATA_W-1:0];
          CFG_GAIN_I:    cfg_q.gain_i    <= cfg_data_i[DATA_W-1:0];
          default: ;
        endcase
      end
      if (load_a) a_valid_q <= in_valid_i;
      if (load_b) b_valid_q <= a_valid_q;
      if (load_c) c_valid_q <= b_valid_q;
      if (load_d) d_valid_q <= c_valid_q;
      if (load_e) e_valid_q <= d_valid_q;
      if (load_out) out_valid_q <= e_valid_q;
      if (load_d && c_valid_q) begin
        prev_err_q <= prev_err_d;
        integ_q    <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_a) begin
      a_raw_q[0]  <= sensor0_raw_i;
      a_raw_q[1]  <= sensor1_raw_i;
      a_raw_q[2]  <= sensor2_raw_i;
      a_raw_q[3]  <= sensor3_raw_i;
      a_raw_q[4]  <= sensor4_raw_i;
      a_restart_q <= restart_i;
    end
    if (load_b) begin
      b_front_q   <= b_front_d;
      b_restart_q <= a_restart_q;
    end
    if (load_c) begin
      c_quot_q    <= c_quot_d;
      c_mask_q    <= b_front_q.mask;
      c_count_q   <= b_front_q.count;
      c_restart_q <= b_restart_q;
    end
    if (load_d) begin
      d_err_q   <= d_err_d;
      d_derr_q  <= d_derr_d;
      d_integ_q <= d_integ_d;
      d_mask_q  <= c_mask_q;
      d_count_q <= c_count_q;
    end
    if (load_e) begin
      e_prod_p_q <= e_prod_p_d;
      e_prod_d_q <= e_prod_d_d;
      e_prod_i_q <= e_prod_i_d;
      e_err_q    <= d_err_q;
      e_mask_q   <= d_mask_q;
      e_count_q  <= d_count_q;
    end
    if (load_out) begin
      drive_q <= drive_d;
      mask_q  <= e_mask_q;
      count_q <= e_count_q;
      err_q   <= e_err_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_o         = drive_q;
  assign on_line_mask_o  = mask_q;
  assign on_line_count_o = count_q;
  assign error_value_o   = err_q;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while the output stage can move");

  a_state_follows_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q && load_d |=> prev_err_q == d_err_q)
    else $error("previous error not taken from the word just passed");

  a_restart_clears_integral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q && c_restart_q && load_d |=> d_integ_q == '0 && integ_q == DATA_W'(d_err_q))
    else $error("restart did not clear the integral");

  a_count_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(on_line_count_o) == $countones(on_line_mask_o))
    else $error("on line count disagrees with mask");
`endif

endmodule

FILE: sim/tb.sv
// testbench of the line sensor pid steering block: drives words, predicts and checks results
module tb;
  import lsps_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int RANDOM_PHASES   = 10;
  localparam int WORDS_PER_PHASE = 183;
  localparam int HOLD_OFF        = 80;
  localparam int SETTLE          = 8;
  localparam int ERROR_SCALE     = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic [SENSOR_COUNT-1:0]  mask;
    logic [COUNT_W-1:0]       count;
    logic signed [ERR_W-1:0]  err;
  } steer_t;

  class steer_board;
    cfg_t   settings;
    longint last_error;
    longint error_sum;
    steer_t expected_steer[$];
    int     mismatches;

    function new();
      settings = '{offsets: '0, threshold: 12'sd512, mode: MODE_DARK, set_point: '0,
                   gain_p: 16'sd20, gain_d: '0, gain_i: '0};
      last_error = 0;
      error_sum  = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_steer.size();
    endfunction

    function longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_OFFSETS:   settings.offsets   = data;
        CFG_THRESH:    settings.threshold = data[THRESH_W-1:0];
        CFG_MODE:      settings.mode      = data[0] ? MODE_LIGHT : MODE_DARK;
        CFG_SET_POINT: settings.set_point = data[DATA_W-1:0];
        CFG_GAIN_P:    settings.gain_p    = data[DATA_W-1:0];
        CFG_GAIN_D:    settings.gain_d    = data[DATA_W-1:0];
        CFG_GAIN_I:    settings.gain_i    = data[DATA_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_word(input logic [READING_BITS-1:0] raw [SENSOR_COUNT],
                               input logic restart);
      longint level, sum, err, drv, weight, thr;
      steer_t e;
      if (restart) begin
        last_error = 0;
        error_sum  = 0;
      end
      thr    = longint'($signed(settings.threshold));
      sum    = 0;
      e.mask  = '0;
      e.count = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        level = longint'(raw[i]) +
                longint'($signed(settings.offsets[i*OFFSET_BITS +: OFFSET_BITS]));
        case (i)
          0: weight = 3;
          1: weight = 2;
          2: weight = 1;
          3: weight = -2;
          default: weight = -3;
        endcase
        if ((settings.mode == MODE_DARK) ? (level < thr) : (level > thr)) begin
          e.mask[i] = 1'b1;
          e.count   = e.count + 1'b1;
        end
        sum += level * weight;
      end
      err = clip((longint'($signed(settings.set_point)) - sum) / ERROR_SCALE, -1024, 1023);
      drv = longint'($signed(settings.gain_p)) * err +
            longint'($signed(settings.gain_d)) * (last_error - err) +
            longint'($signed(settings.gain_i)) * error_sum;
      drv = clip(drv, -32768, 32767);
      last_error = err;
      error_sum  = clip(error_sum + err, -32768, 32767);
      e.drive = DATA_W'(drv);
      e.err   = ERR_W'(err);
      expected_steer.push_back(e);
    endfunction

    task report(input string what);
      mismatches++;
      $display("mismatch: %s", what);
    endtask

    task check_result(input logic signed [DATA_W-1:0] drive,
                      input logic [SENSOR_COUNT-1:0] mask,
                      input logic [COUNT_W-1:0] count,
                      input logic signed [ERR_W-1:0] err);
      steer_t e;
      if (expected_steer.size() == 0) begin
        report($sformatf("result with nothing expected, drive %0d error %0d", drive, err));
      end else begin
        e = expected_steer.pop_front();
        if (drive !== e.drive)
          report($sformatf("drive got %0d want %0d", drive, e.drive));
        if (mask !== e.mask)
          report($sformatf("on_line_mask got %b want %b", mask, e.mask));
        if (count !== e.count)
          report($sformatf("on_line_count got %0d want %0d", count, e.count));
        if (err !== e.err)
          report($sformatf("error_value got %0d want %0d", err, e.err));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [READING_BITS-1:0] sensor0_raw_i = '0;
  logic [READING_BITS-1:0] sensor1_raw_i = '0;
  logic [READING_BITS-1:0] sensor2_raw_i = '0;
  logic [READING_BITS-1:0] sensor3_raw_i = '0;
  logic [READING_BITS-1:0] sensor4_raw_i = '0;
  logic restart_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] drive_o;
  logic [SENSOR_COUNT-1:0] on_line_mask_o;
  logic [COUNT_W-1:0] on_line_count_o;
  logic signed [ERR_W-1:0] error_value_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  steer_board sb;
  int tx_style = 1;
  int rx_style = 1;
  int hold_off_cycles = 0;

  line_sensor_pid_steering DUT (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int draw_gap(input int style);
    case (style)
      0: return 0;
      1: return int'($urandom_range(0, 15));
      default: return int'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word(input int span);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
      1: return DATA_W'($urandom);
      default: return DATA_W'(int'($urandom_range(0, span)) - span / 2);
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    logic signed [OFFSET_BITS-1:0] off;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      case ($urandom_range(0, 3))
        0: off = $urandom_range(0, 1) ? 11'sh3FF : 11'sh400;
        1: off = OFFSET_BITS'($urandom);
        default: off = OFFSET_BITS'(int'($urandom_range(0, 128)) - 64);
      endcase
      c.offsets[i*OFFSET_BITS +: OFFSET_BITS] = off;
    end
    case ($urandom_range(0, 3))
      0: c.threshold = $urandom_range(0, 1) ? 12'sh7FF : 12'sh800;
      1: c.threshold = THRESH_W'($urandom);
      default: c.threshold = THRESH_W'($urandom_range(0, 1023));
    endcase
    c.mode      = $urandom_range(0, 1) ? MODE_LIGHT : MODE_DARK;
    c.set_point = pick_word(4000);
    c.gain_p    = pick_word(80);
    c.gain_d    = pick_word(80);
    c.gain_i    = pick_word(8);
    return c;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] upper_noise();
    return ($urandom_range(0, 3) == 0) ? CFG_DATA_W'({$urandom, $urandom}) : '0;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic load_settings(input cfg_t c);
    logic [CFG_DATA_W-1:0] data;
    write_reg(CFG_OFFSETS, c.offsets);
    data = upper_noise();
    data[THRESH_W-1:0] = c.threshold;
    write_reg(CFG_THRESH, data);
    data = upper_noise();
    data[0] = c.mode;
    write_reg(CFG_MODE, data);
    data = upper_noise();
    data[DATA_W-1:0] = c.set_point;
    write_reg(CFG_SET_POINT, data);
    data = upper_noise();
    data[DATA_W-1:0] = c.gain_p;
    write_reg(CFG_GAIN_P, data);
    data = upper_noise();
    data[DATA_W-1:0] = c.gain_d;
    write_reg(CFG_GAIN_D, data);
    data = upper_noise();
    data[DATA_W-1:0] = c.gain_i;
    write_reg(CFG_GAIN_I, data);
    // unknown index must leave every register alone
    write_reg(CFG_SPARE_IDX, CFG_DATA_W'({$urandom, $urandom}));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_word(input logic [READING_BITS-1:0] raw [SENSOR_COUNT],
                           input logic restart);
    int gap;
    gap = draw_gap(tx_style);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sensor0_raw_i <= raw[0];
    sensor1_raw_i <= raw[1];
    sensor2_raw_i <= raw[2];
    sensor3_raw_i <= raw[3];
    sensor4_raw_i <= raw[4];
    restart_i     <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    sb.predict_word(raw, restart);
  endtask

  task automatic send_random_word(input int restart_odds);
    logic [READING_BITS-1:0] raw [SENSOR_COUNT];
    int level;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      // raw reading that lands the level right on the threshold
      level = int'($signed(sb.settings.threshold)) -
              int'($signed(sb.settings.offsets[i*OFFSET_BITS +: OFFSET_BITS]));
      case ($urandom_range(0, 7))
        0: raw[i] = '0;
        1: raw[i] = '1;
        2, 3: raw[i] = (level >= 0 && level < 2 ** READING_BITS) ?
                       level[READING_BITS-1:0] : READING_BITS'($urandom);
        default: raw[i] = READING_BITS'($urandom);
      endcase
    end
    send_word(raw, $urandom_range(1, restart_odds) == 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin : stimulus
    cfg_t phase_cfg;
    int restart_odds;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: dark line, threshold 512, no offsets
    send_word('{SENSOR_COUNT{10'd0}}, 1'b1);
    send_word('{SENSOR_COUNT{10'd1023}}, 1'b0);
    send_word('{SENSOR_COUNT{10'd512}}, 1'b0);
    send_word('{SENSOR_COUNT{10'd511}}, 1'b0);
    send_word('{10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd0}, 1'b0);
    send_word('{10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023}, 1'b0);
    send_word('{10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA}, 1'b0);
    send_word('{10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155}, 1'b1);
    drain();

    phase_cfg = '{offsets: '0, threshold: 12'sd512, mode: MODE_LIGHT, set_point: DATA_MAX,
                  gain_p: DATA_MAX, gain_d: DATA_MIN, gain_i: DATA_MAX};
    load_settings(phase_cfg);
    send_word('{SENSOR_COUNT{10'd512}}, 1'b1);
    send_word('{SENSOR_COUNT{10'd513}}, 1'b0);
    send_word('{SENSOR_COUNT{10'd1023}}, 1'b0);
    send_word('{SENSOR_COUNT{10'd0}}, 1'b0);
    send_word('{10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023}, 1'b0);
    send_word('{SENSOR_COUNT{10'd1023}}, 1'b0);
    drain();

    phase_cfg = '{offsets: {SENSOR_COUNT{11'h400}}, threshold: 12'sh800, mode: MODE_DARK,
                  set_point: DATA_MIN, gain_p: DATA_MIN, gain_d: DATA_MAX, gain_i: DATA_MIN};
    load_settings(phase_cfg);
    send_word('{SENSOR_COUNT{10'd0}}, 1'b1);
    send_word('{SENSOR_COUNT{10'd1023}}, 1'b0);
    send_word('{10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd0}, 1'b0);
    send_word('{10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023}, 1'b0);
    drain();

    phase_cfg = '{offsets: {SENSOR_COUNT{11'h3FF}}, threshold: 12'sd2046, mode: MODE_LIGHT,
                  set_point: '0, gain_p: 16'sd3, gain_d: 16'sd1, gain_i: 16'sd1};
    load_settings(phase_cfg);
    send_word('{SENSOR_COUNT{10'd1023}}, 1'b0);
    send_word('{10'd1023, 10'd1022, 10'd1023, 10'd1022, 10'd1023}, 1'b0);
    send_word('{SENSOR_COUNT{10'd0}}, 1'b1);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      phase_cfg = random_settings();
      // steady one-sided error drives the integral into its clamp
      if (phase == 1) phase_cfg.set_point = DATA_MAX;
      if (phase == 3) phase_cfg.set_point = DATA_MIN;
      load_settings(phase_cfg);
      tx_style     = phase % 3;
      rx_style     = (phase + 1) % 3;
      restart_odds = (phase % 2 == 1) ? 200 : 16;
      if (phase == 2) begin
        tx_style        = 0;
        hold_off_cycles = HOLD_OFF;
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (phase == 4 && n == WORDS_PER_PHASE / 2) drain();
        send_random_word(restart_odds);
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_off_cycles > 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = draw_gap(rx_style);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(drive_o, on_line_mask_o, on_line_count_o, error_value_o);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end
endmodule
